/* rtl/core/bmsw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsw_pkg
// types, storage map and lookup functions of the banked register mode switch
// ----------------------------------------------------------------------------
package bmsw_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned MEM_DEPTH = 44;
	localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

	// storage map: visible set, then the banks, then the live saved status
	localparam logic [ADDR_W-1:0] VIS_R8    = ADDR_W'(8);
	localparam logic [ADDR_W-1:0] VIS_R13   = ADDR_W'(13);
	localparam logic [ADDR_W-1:0] VIS_R14   = ADDR_W'(14);
	localparam logic [ADDR_W-1:0] VIS_R15   = ADDR_W'(15);
	localparam logic [ADDR_W-1:0] USR_BASE  = ADDR_W'(16);
	localparam logic [ADDR_W-1:0] FIQ_BASE  = ADDR_W'(23);
	localparam logic [ADDR_W-1:0] STK_BASE  = ADDR_W'(30);
	localparam logic [ADDR_W-1:0] LNK_BASE  = ADDR_W'(34);
	localparam logic [ADDR_W-1:0] SPSR_BASE = ADDR_W'(38);
	localparam logic [ADDR_W-1:0] SPSR_NOW  = ADDR_W'(43);

	localparam logic [DATA_W-1:0] USR_SP_INIT = 32'h0300_7F00;
	localparam logic [DATA_W-1:0] SVC_SP_INIT = 32'h0300_7FE0;
	localparam logic [DATA_W-1:0] IRQ_SP_INIT = 32'h0300_7FA0;
	localparam logic [DATA_W-1:0] ROM_ENTRY   = 32'h0800_0000;

	localparam logic [4:0] CODE_USR = 5'h10;
	localparam logic [4:0] CODE_FIQ = 5'h11;
	localparam logic [4:0] CODE_IRQ = 5'h12;
	localparam logic [4:0] CODE_SVC = 5'h13;
	localparam logic [4:0] CODE_ABT = 5'h17;
	localparam logic [4:0] CODE_UND = 5'h1B;
	localparam logic [4:0] CODE_SYS = 5'h1F;

	typedef enum logic [2:0] {
		MODE_USR = 3'd0,
		MODE_FIQ = 3'd1,
		MODE_IRQ = 3'd2,
		MODE_SVC = 3'd3,
		MODE_ABT = 3'd4,
		MODE_UND = 3'd5,
		MODE_SYS = 3'd6
	} mode_t;

	typedef enum logic [2:0] {
		ACC_RD_REG  = 3'd0,
		ACC_WR_REG  = 3'd1,
		ACC_RD_SPSR = 3'd2,
		ACC_WR_SPSR = 3'd3,
		ACC_CHG     = 3'd4
	} acc_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SWAP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic [3:0]        reg_index;
		logic [DATA_W-1:0] write_data;
		logic [4:0]        new_mode_code;
	} in_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [2:0]        current_mode;
		logic              bad_mode;
	} out_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic              hit;
		mode_t             mode;
	} decode_t;

	typedef struct packed {
		logic [ADDR_W-1:0] vis;
		logic [ADDR_W-1:0] bank;
	} map_t;

	function automatic logic [4:0] mode_code(input mode_t m);
		logic [4:0] c;
		unique case (m)
			MODE_USR: c = CODE_USR;
			MODE_FIQ: c = CODE_FIQ;
			MODE_IRQ: c = CODE_IRQ;
			MODE_SVC: c = CODE_SVC;
			MODE_ABT: c = CODE_ABT;
			MODE_UND: c = CODE_UND;
			default:  c = CODE_SYS;
		endcase
		return c;
	endfunction

	function automatic decode_t code_to_mode(input logic [4:0] c);
		decode_t d;
		d.hit  = 1'b1;
		d.mode = MODE_SYS;
		unique case (c)
			CODE_USR: d.mode = MODE_USR;
			CODE_FIQ: d.mode = MODE_FIQ;
			CODE_IRQ: d.mode = MODE_IRQ;
			CODE_SVC: d.mode = MODE_SVC;
			CODE_ABT: d.mode = MODE_ABT;
			CODE_UND: d.mode = MODE_UND;
			CODE_SYS: d.mode = MODE_SYS;
			default:  d.hit  = 1'b0;
		endcase
		return d;
	endfunction

	// boot contents of an entry never written since reset or a boot restart
	function automatic logic [DATA_W-1:0] boot_val(input logic [ADDR_W-1:0] a,
			input logic rom);
		logic [DATA_W-1:0] v;
		v = '0;
		if (a == VIS_R13 || a == USR_BASE + ADDR_W'(5)) begin
			v = USR_SP_INIT;
		end else if (a == VIS_R14) begin
			v = ROM_ENTRY;
		end else if (a == VIS_R15) begin
			v = rom ? '0 : ROM_ENTRY;
		end else if (a == STK_BASE + ADDR_W'(1)) begin
			v = SVC_SP_INIT;
		end else if (a == STK_BASE) begin
			v = IRQ_SP_INIT;
		end
		return v;
	endfunction

	// one copy step of a bank swap: visible side and bank side of the pair
	function automatic map_t bank_map(input mode_t m, input logic [2:0] step);
		map_t       r;
		logic [1:0] i2;
		logic [2:0] i1;
		i2 = 2'(m - MODE_IRQ);
		i1 = 3'(m - MODE_FIQ);
		r.vis  = VIS_R8 + ADDR_W'(step);
		r.bank = USR_BASE + ADDR_W'(step);
		if (m == MODE_FIQ) begin
			if (step == 3'd7) begin
				r.vis  = SPSR_NOW;
				r.bank = SPSR_BASE;
			end else begin
				r.bank = FIQ_BASE + ADDR_W'(step);
			end
		end else if (m == MODE_IRQ || m == MODE_SVC || m == MODE_ABT || m == MODE_UND) begin
			if (step == 3'd5) begin
				r.vis  = VIS_R13;
				r.bank = STK_BASE + ADDR_W'(i2);
			end else if (step == 3'd6) begin
				r.vis  = VIS_R14;
				r.bank = LNK_BASE + ADDR_W'(i2);
			end else if (step == 3'd7) begin
				r.vis  = SPSR_NOW;
				r.bank = SPSR_BASE + ADDR_W'(i1);
			end
		end else if (step == 3'd7) begin
			// user and system have seven entries: repeat the last copy
			r.vis  = VIS_R14;
			r.bank = USR_BASE + ADDR_W'(6);
		end
		return r;
	endfunction

endpackage

/* rtl/core/bmsw_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsw_store
// register storage: one memory, per-entry valid bits and write forwarding
// ----------------------------------------------------------------------------
module bmsw_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        boot_rom,
	input  bmsw_pkg::mem_req_t          req,
	output logic [bmsw_pkg::DATA_W-1:0] rdata
);

	logic [bmsw_pkg::DATA_W-1:0]    mem [bmsw_pkg::MEM_DEPTH];
	logic [bmsw_pkg::MEM_DEPTH-1:0] vld_q;
	logic [bmsw_pkg::DATA_W-1:0]    rdata_s1;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// entries not written since a boot restart read their boot value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cfg_we) begin
			vld_q <= '0;
		end else if (req.we) begin
			vld_q[req.waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			if (req.we && req.waddr == req.raddr) begin
				rdata_s1 <= req.wdata;
			end else if (vld_q[req.raddr]) begin
				rdata_s1 <= mem[req.raddr];
			end else begin
				rdata_s1 <= bmsw_pkg::boot_val(req.raddr, boot_rom);
			end
		end
	end

	assign rdata = rdata_s1;

endmodule

/* rtl/core/bmsw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsw_ctrl
// request decode, bank swap sequencer and mode register
// ----------------------------------------------------------------------------
module bmsw_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_boot,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bmsw_pkg::in_t               in_data,
	output logic                        res_valid,
	input  logic                        res_take,
	output bmsw_pkg::out_t              res_data,
	output bmsw_pkg::mem_req_t          mem_req,
	input  logic [bmsw_pkg::DATA_W-1:0] mem_rdata
);

	bmsw_pkg::state_t                state_q, state_d;
	bmsw_pkg::mode_t                 mode_q, old_q, swap_mode;
	logic [4:0]                      cnt_q;
	logic                            pend_s1;
	logic [bmsw_pkg::ADDR_W-1:0]     dst_s1, swap_dst;
	bmsw_pkg::out_t                  res_q;
	bmsw_pkg::acc_t                  acc;
	bmsw_pkg::decode_t               dec;
	bmsw_pkg::map_t                  map;
	logic                            same;
	logic                            go_swap;
	logic                            accept;

	assign acc     = bmsw_pkg::acc_t'(in_data.mode);
	assign dec     = bmsw_pkg::code_to_mode(in_data.new_mode_code);
	assign same    = in_data.new_mode_code == bmsw_pkg::mode_code(mode_q);
	assign go_swap = acc == bmsw_pkg::ACC_CHG && !same && dec.hit;
	assign accept  = state_q == bmsw_pkg::ST_IDLE && in_valid;

	// cnt_q: bit 4 all reads issued, bit 3 load phase, bits 2:0 step
	assign swap_mode = cnt_q[3] ? mode_q : old_q;
	assign map       = bmsw_pkg::bank_map(swap_mode, cnt_q[2:0]);
	assign swap_dst  = cnt_q[3] ? map.vis : map.bank;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bmsw_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (acc == bmsw_pkg::ACC_RD_REG || acc == bmsw_pkg::ACC_RD_SPSR) begin
						state_d = bmsw_pkg::ST_READ;
					end else if (go_swap) begin
						state_d = bmsw_pkg::ST_SWAP;
					end else begin
						state_d = bmsw_pkg::ST_DONE;
					end
				end
			end
			bmsw_pkg::ST_READ: state_d = bmsw_pkg::ST_DONE;
			bmsw_pkg::ST_SWAP: begin
				if (cnt_q[4]) begin
					state_d = bmsw_pkg::ST_DONE;
				end
			end
			bmsw_pkg::ST_DONE: begin
				if (res_take) begin
					state_d = bmsw_pkg::ST_IDLE;
				end
			end
			default: state_d = bmsw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mem_req   = '0;
		in_ready  = state_q == bmsw_pkg::ST_IDLE;
		res_valid = state_q == bmsw_pkg::ST_DONE;
		res_data  = res_q;
		unique case (state_q)
			bmsw_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (acc)
						bmsw_pkg::ACC_RD_REG: begin
							mem_req.re    = 1'b1;
							mem_req.raddr = bmsw_pkg::ADDR_W'(in_data.reg_index);
						end
						bmsw_pkg::ACC_WR_REG: begin
							mem_req.we    = 1'b1;
							mem_req.waddr = bmsw_pkg::ADDR_W'(in_data.reg_index);
							mem_req.wdata = in_data.write_data;
						end
						bmsw_pkg::ACC_RD_SPSR: begin
							mem_req.re    = 1'b1;
							mem_req.raddr = bmsw_pkg::SPSR_NOW;
						end
						bmsw_pkg::ACC_WR_SPSR: begin
							mem_req.we    = 1'b1;
							mem_req.waddr = bmsw_pkg::SPSR_NOW;
							mem_req.wdata = in_data.write_data;
						end
						default: mem_req = '0;
					endcase
				end
			end
			bmsw_pkg::ST_SWAP: begin
				// read one entry per cycle, write the previous one back
				mem_req.re    = !cnt_q[4];
				mem_req.raddr = cnt_q[3] ? map.bank : map.vis;
				mem_req.we    = pend_s1;
				mem_req.waddr = dst_s1;
				mem_req.wdata = mem_rdata;
			end
			default: mem_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmsw_pkg::ST_IDLE;
			mode_q  <= bmsw_pkg::MODE_SYS;
			pend_s1 <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= state_q == bmsw_pkg::ST_SWAP && !cnt_q[4];
			if (cfg_we) begin
				mode_q <= cfg_boot ? bmsw_pkg::MODE_SVC : bmsw_pkg::MODE_SYS;
			end else if (accept && go_swap) begin
				mode_q <= dec.mode;
			end
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == bmsw_pkg::ST_SWAP) begin
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		dst_s1 <= swap_dst;
		if (accept) begin
			old_q              <= mode_q;
			res_q.read_data    <= '0;
			res_q.current_mode <= go_swap ? dec.mode : mode_q;
			res_q.bad_mode     <= acc == bmsw_pkg::ACC_CHG && !same && !dec.hit;
		end else if (state_q == bmsw_pkg::ST_READ) begin
			res_q.read_data <= mem_rdata;
		end
	end

endmodule

/* rtl/core/banked_register_mode_switch_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_register_mode_switch_core
// banked register file with seven processor modes and bank swapping
// ----------------------------------------------------------------------------
// in_valid/in_ready: one request, a register or saved status read or write,
//   or a mode change by architectural mode code
// out_valid/out_ready: one result per request, read data (zero otherwise),
//   the mode after the request and a bad mode flag
// cfg_we/cfg_wdata: boot_from_rom; write only while idle (the block has no
//   check); the write resets all registers, banks and mode to that boot state
// a write or a no-op mode change goes straight to its result; a read waits
//   for the synchronous memory read, and a real mode change for its 16 bank
//   copies through the one memory, reading one entry while writing the last
// one request in flight; the next is taken the cycle after the result moves
//   into the output register
// reset: arst_n boots into system mode with PC 0x08000000; per-entry valid
//   bits supply the boot values, no clearing pass
// stall: a held output keeps its result; the core takes one more request
//   and then waits with that result until out_ready frees the output register
// ----------------------------------------------------------------------------
module banked_register_mode_switch_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bmsw_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output bmsw_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic           cfg_wdata
);

	logic                        boot_q;
	logic                        out_valid_q;
	bmsw_pkg::out_t              out_q;
	logic                        res_valid;
	logic                        res_take;
	bmsw_pkg::out_t              res_data;
	bmsw_pkg::mem_req_t          mem_req;
	logic [bmsw_pkg::DATA_W-1:0] mem_rdata;

	// boot selection register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q <= 1'b0;
		end else if (cfg_we) begin
			boot_q <= cfg_wdata;
		end
	end

	// output register is free when empty or being drained this cycle
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// decode and bank swap sequencing
	bmsw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_boot  (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res_data  (res_data),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// visible registers, banks and saved status words
	bmsw_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.boot_rom (boot_q),
		.req      (mem_req),
		.rdata    (mem_rdata)
	);

endmodule
